@@ hw/rtl/ccd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types, constants and the bytewise CRC-16/MODBUS update for the
// command deframer.
// ----------------------------------------------------------------------------
package ccd_pkg;

    localparam int FRAME_LEN = 7;
    localparam int CRC_SPAN  = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] WRITE_HEADER_RST = 8'hAA;
    localparam logic [7:0] READ_HEADER_RST  = 8'hBB;

    // configuration register indexes
    localparam logic REG_WRITE_HEADER = 1'b0;
    localparam logic REG_READ_HEADER  = 1'b1;

    // byte positions within a frame
    localparam logic [2:0] POS_HUNT     = 3'd0;
    localparam logic [2:0] POS_BLOCK_HI = 3'd1;
    localparam logic [2:0] POS_BLOCK_LO = 3'd2;
    localparam logic [2:0] POS_WORD_HI  = 3'd3;
    localparam logic [2:0] POS_WORD_LO  = 3'd4;
    localparam logic [2:0] POS_CHECK_HI = 3'(FRAME_LEN - 2);
    localparam logic [2:0] POS_CHECK_LO = 3'(FRAME_LEN - 1);
    localparam logic [2:0] POS_CRC_END  = 3'(CRC_SPAN);

    // result beat, packed from the lowest bit: is_read, block_number,
    // pattern_word, check_ok, zero pad to 40 bits
    typedef struct packed {
        logic [5:0]  pad;
        logic        check_ok;
        logic [15:0] pattern_word;
        logic [15:0] block_number;
        logic        is_read;
    } ccd_result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ hw/rtl/ccd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_parser
// Header hunt, field capture and running CRC. Produces one result in the
// cycle the last frame byte is accepted.
// ----------------------------------------------------------------------------
module ccd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 beat_en,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           write_header,
    input  logic [7:0]           read_header,
    output logic                 res_valid,
    output ccd_pkg::ccd_result_t res
);
    import ccd_pkg::*;

    logic [2:0]  pos_reg,     pos_next;
    logic [15:0] crc_reg,     crc_next;
    logic        is_read_reg, is_read_next;
    logic [15:0] block_reg,   block_next;
    logic [15:0] word_reg,    word_next;
    logic [7:0]  chk_hi_reg,  chk_hi_next;

    logic [15:0] crc_fed;
    logic        hdr_hit;

    assign crc_fed = crc_feed((pos_reg == POS_HUNT) ? CRC_INIT : crc_reg, rx_byte);
    assign hdr_hit = (rx_byte == write_header) || (rx_byte == read_header);

    always_comb begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        is_read_next = is_read_reg;
        block_next   = block_reg;
        word_next    = word_reg;
        chk_hi_next  = chk_hi_reg;
        res_valid    = 1'b0;

        res.pad          = '0;
        res.is_read      = is_read_reg;
        res.block_number = block_reg;
        res.pattern_word = word_reg;
        res.check_ok     = ({chk_hi_reg, rx_byte} == crc_reg);

        if (beat_en) begin
            if (pos_reg == POS_HUNT) begin
                if (hdr_hit) begin
                    // write header wins when both registers match
                    is_read_next = (rx_byte != write_header);
                    crc_next     = crc_fed;
                    block_next   = '0;
                    word_next    = '0;
                    chk_hi_next  = '0;
                    pos_next     = POS_BLOCK_HI;
                end
            end else begin
                if (pos_reg < POS_CRC_END) begin
                    crc_next = crc_fed;
                end
                case (pos_reg)
                    POS_BLOCK_HI, POS_BLOCK_LO: block_next  = {block_reg[7:0], rx_byte};
                    POS_WORD_HI, POS_WORD_LO:   word_next   = {word_reg[7:0], rx_byte};
                    POS_CHECK_HI:               chk_hi_next = rx_byte;
                    default: ;
                endcase
                if (pos_reg >= POS_CHECK_LO) begin
                    res_valid = 1'b1;
                    pos_next  = POS_HUNT;
                    crc_next  = CRC_INIT;
                end else begin
                    pos_next = pos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_HUNT;
            crc_reg     <= CRC_INIT;
            is_read_reg <= 1'b0;
            block_reg   <= '0;
            word_reg    <= '0;
            chk_hi_reg  <= '0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            is_read_reg <= is_read_next;
            block_reg   <= block_next;
            word_reg    <= word_next;
            chk_hi_reg  <= chk_hi_next;
        end
    end

endmodule

@@ hw/rtl/crc_checked_command_deframer_top.sv @@
`timescale 1ns / 1ps
// A result beat is registered in the output register, or in the skid entry if that is full.
// Throughput: one byte per cycle while s_tready is high; parse and CRC steps are combinational.
// A two-entry output buffer (register plus skid) lets input continue while a result waits;
// s_tready drops only when both entries are full.
// Reset (aresetn low, synchronous): hunting, CRC at 0xFFFF, headers 0xAA / 0xBB, outputs empty.
// ----------------------------------------------------------------------------
// crc_checked_command_deframer_top
// Serial command deframer with CRC-16/MODBUS check: header hunt, field
// capture, check compare and a buffered result stream.
// ----------------------------------------------------------------------------
module crc_checked_command_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] is_read, [16:1] block_number,
                                   // [32:17] pattern_word, [33] check_ok, zero pad
);
    import ccd_pkg::*;

    logic [7:0]  write_header_reg;
    logic [7:0]  read_header_reg;

    logic        res_valid;
    ccd_result_t res;

    logic        out_valid_reg,  out_valid_next;
    ccd_result_t out_data_reg,   out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    ccd_result_t skid_data_reg,  skid_data_next;

    logic        beat_in;
    logic        pop;

    assign s_tready = !skid_valid_reg;
    assign beat_in  = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_header_reg <= WRITE_HEADER_RST;
            read_header_reg  <= READ_HEADER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WRITE_HEADER: write_header_reg <= cfg_wdata;
                REG_READ_HEADER:  read_header_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ccd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_en      (beat_in),
        .rx_byte      (s_tdata),
        .write_header (write_header_reg),
        .read_header  (read_header_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end else if (res_valid) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ sim/crc_checked_command_deframer_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_command_deframer_top_test
// Self-checking bench for the command deframer. A short directed table covers
// hunt drops, write/read frames, field extremes, header bytes inside a frame,
// equal headers and a bad check value. Random frames, noise and truncated
// frames follow under four header settings and four idle/stall mixes. Every
// result beat is checked against a local frame tracker with its own CRC.
// ----------------------------------------------------------------------------
module crc_checked_command_deframer_top_test;
    import ccd_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    // how a stimulus byte is formed; check bytes are taken from the running CRC
    typedef enum logic [2:0] {
        BYTE_RAW,
        CHECK_HI_GOOD,
        CHECK_LO_GOOD,
        CHECK_LO_BAD,
        SET_HEADERS
    } stim_kind_t;

    typedef struct packed {
        stim_kind_t  kind;
        logic [7:0]  val;
        logic        typed;
        logic        is_read;
        logic [15:0] block_number;
        logic [15:0] pattern_word;
        logic        check_ok;
    } stim_row_t;

    localparam stim_row_t DIRECTED [23] = '{
        '{BYTE_RAW,      8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0}, // dropped
        '{BYTE_RAW,      8'hAA, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{CHECK_HI_GOOD, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{CHECK_LO_GOOD, 8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1},
        // read frame, header values as payload, bad check
        '{BYTE_RAW,      8'hBB, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'hAA, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'hBB, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{CHECK_HI_GOOD, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{CHECK_LO_BAD,  8'h00, 1'b1, 1'b1, 16'hAABB, 16'hFFFF, 1'b0},
        // both headers equal: frame counts as a write
        '{SET_HEADERS,   8'h5A, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h5A, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h12, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h34, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h56, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{BYTE_RAW,      8'h78, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{CHECK_HI_GOOD, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{CHECK_LO_GOOD, 8'h00, 1'b1, 1'b0, 16'h1234, 16'h5678, 1'b1}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = REG_WRITE_HEADER;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [0] is_read, [16:1] block_number,
                                    // [32:17] pattern_word, [33] check_ok, pad

    // frame tracker state
    logic [7:0]  write_hdr;
    logic [7:0]  read_hdr;
    logic [2:0]  frame_pos;
    logic [15:0] crc_acc;
    logic        frame_is_read;
    logic [15:0] block_acc;
    logic [15:0] word_acc;
    logic [7:0]  check_hi;

    ccd_result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int bytes_sent = 0;
    int framed_bytes = 0;
    int crc_pass_seen = 0;
    int crc_fail_seen = 0;
    int quiet_cycles = 0;

    crc_checked_command_deframer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    // reflected CRC-16, one data bit at a time, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
        logic [15:0] acc;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            if (acc[0] ^ b[i]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, output bit taken,
                                output bit emitted, output ccd_result_t res);
        taken = 1'b1;
        emitted = 1'b0;
        res = '0;
        if (frame_pos == POS_HUNT) begin
            if (b == write_hdr || b == read_hdr) begin
                frame_is_read = (b != write_hdr);
                crc_acc = crc_byte(CRC_INIT, b);
                block_acc = '0;
                word_acc = '0;
                check_hi = '0;
                frame_pos = POS_BLOCK_HI;
            end else begin
                taken = 1'b0;
            end
        end else begin
            if (frame_pos < POS_CRC_END) begin
                crc_acc = crc_byte(crc_acc, b);
            end
            case (frame_pos)
                POS_BLOCK_HI, POS_BLOCK_LO: block_acc = {block_acc[7:0], b};
                POS_WORD_HI, POS_WORD_LO:   word_acc = {word_acc[7:0], b};
                POS_CHECK_HI:               check_hi = b;
                default: ;
            endcase
            if (frame_pos == POS_CHECK_LO) begin
                emitted = 1'b1;
                res.is_read = frame_is_read;
                res.block_number = block_acc;
                res.pattern_word = word_acc;
                res.check_ok = ({check_hi, b} == crc_acc);
                frame_pos = POS_HUNT;
                crc_acc = CRC_INIT;
            end else begin
                frame_pos = frame_pos + 3'd1;
            end
        end
    endtask

    // forms the byte, tracks it, queues the expectation, then hands it over
    task automatic send_row(input stim_kind_t kind, input logic [7:0] val,
                            input bit typed, input ccd_result_t typed_res);
        logic [7:0]  b;
        bit          taken;
        bit          emitted;
        ccd_result_t res;
        case (kind)
            CHECK_HI_GOOD: b = crc_acc[15:8];
            CHECK_LO_GOOD: b = crc_acc[7:0];
            CHECK_LO_BAD:  b = crc_acc[7:0] ^ 8'h01;
            default:       b = val;
        endcase
        deframe_byte(b, taken, emitted, res);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else if (emitted) begin
            pending_results.push_back(res);
        end
        bytes_sent++;
        if (taken) begin
            framed_bytes++;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_byte(input stim_kind_t kind, input logic [7:0] val);
        send_row(kind, val, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_headers(input logic [7:0] wr_hdr, input logic [7:0] rd_hdr);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_WRITE_HEADER;
        cfg_wdata <= wr_hdr;
        @(posedge aclk);
        cfg_addr <= REG_READ_HEADER;
        cfg_wdata <= rd_hdr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        write_hdr = wr_hdr;
        read_hdr = rd_hdr;
    endtask

    // mostly well-formed frames; some noise and truncated frames
    task automatic run_phase(input int items);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_byte(BYTE_RAW, $urandom_range(1) ? read_hdr : write_hdr);
                repeat (4) send_byte(BYTE_RAW, 8'($urandom_range(255)));
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_byte(CHECK_HI_GOOD, 8'h00);
                    send_byte(CHECK_LO_GOOD, 8'h00);
                end else if (pick < 85) begin
                    send_byte(CHECK_HI_GOOD, 8'h00);
                    send_byte(CHECK_LO_BAD, 8'h00);
                end else begin
                    repeat (2) send_byte(BYTE_RAW, 8'($urandom_range(255)));
                end
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3)) send_byte(BYTE_RAW, 8'($urandom_range(255)));
            end else begin
                send_byte(BYTE_RAW, $urandom_range(1) ? read_hdr : write_hdr);
                repeat ($urandom_range(4)) send_byte(BYTE_RAW, 8'($urandom_range(255)));
            end
        end
        // close any open frame so the block is idle before the next setting
        while (frame_pos != POS_HUNT) begin
            send_byte(BYTE_RAW, 8'($urandom_range(255)));
        end
    endtask

    task automatic check_result(input logic [39:0] beat);
        ccd_result_t got;
        ccd_result_t want;
        got = beat;
        if (pending_results.size() == 0) begin
            $error("result beat %h with no frame pending", beat);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.check_ok === 1'b1) crc_pass_seen++;
            else crc_fail_seen++;
            if (got.is_read !== want.is_read) begin
                $error("is_read: expected %0d, got %0d", want.is_read, got.is_read);
                fail_count++;
            end
            if (got.block_number !== want.block_number) begin
                $error("block_number: expected %h, got %h",
                       want.block_number, got.block_number);
                fail_count++;
            end
            if (got.pattern_word !== want.pattern_word) begin
                $error("pattern_word: expected %h, got %h",
                       want.pattern_word, got.pattern_word);
                fail_count++;
            end
            if (got.check_ok !== want.check_ok) begin
                $error("check_ok: expected %0d, got %0d", want.check_ok, got.check_ok);
                fail_count++;
            end
            if (got.pad !== '0) begin
                $error("pad: expected 0, got %h", got.pad);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            check_result(m_tdata);
        end
    end

    // watchdog: cycles without any beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        ccd_result_t typed_res;
        logic [7:0]  rand_wr;
        logic [7:0]  rand_rd;

        write_hdr = WRITE_HEADER_RST;
        read_hdr = READ_HEADER_RST;
        frame_pos = POS_HUNT;
        crc_acc = CRC_INIT;
        frame_is_read = 1'b0;
        block_acc = '0;
        word_acc = '0;
        check_hi = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == SET_HEADERS) begin
                program_headers(DIRECTED[i].val, DIRECTED[i].val);
            end else begin
                typed_res = '0;
                typed_res.is_read = DIRECTED[i].is_read;
                typed_res.block_number = DIRECTED[i].block_number;
                typed_res.pattern_word = DIRECTED[i].pattern_word;
                typed_res.check_ok = DIRECTED[i].check_ok;
                send_row(DIRECTED[i].kind, DIRECTED[i].val, DIRECTED[i].typed, typed_res);
            end
        end

        program_headers(WRITE_HEADER_RST, READ_HEADER_RST);
        run_phase(105);

        program_headers(8'h00, 8'hFF);
        send_idle_pct = 50;
        run_phase(105);

        program_headers(8'hFF, 8'h00);
        send_idle_pct = 0;
        recv_stall_pct = 50;
        run_phase(105);

        rand_wr = 8'($urandom_range(255));
        rand_rd = ($urandom_range(3) == 0) ? rand_wr : 8'($urandom_range(255));
        program_headers(rand_wr, rand_rd);
        send_idle_pct = 35;
        recv_stall_pct = 35;
        run_phase(105);

        drain_results();
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes, %0d inside frames, under five header settings",
                 bytes_sent, framed_bytes);
        $display("Checked %0d frames: %0d with matching CRC, %0d with mismatch",
                 crc_pass_seen + crc_fail_seen, crc_pass_seen, crc_fail_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
